@@ rtl/windowed_sample_ring_buffer_defines.svh @@
// Assertion macros used by the ring buffer back end.
`ifndef WINDOWED_SAMPLE_RING_BUFFER_DEFINES_SVH
`define WINDOWED_SAMPLE_RING_BUFFER_DEFINES_SVH

// Checked on every edge outside reset.
`define WSRB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wsrb assertion failed");

// Checked on every edge, reset included.
`define WSRB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("wsrb assertion failed");

`endif

@@ rtl/wsrb_pkg.sv @@
// Types and constants of the windowed sample ring buffer.
`timescale 1ns / 1ps
package wsrb_pkg;

   localparam int TS_W  = 63;
   localparam int PL_W  = 64;
   localparam int WIN_W = 64;
   localparam int CAP_W = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   typedef enum logic {
      OP_SAVE  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // one classified item: a save carries {0,timestamp} and payload,
   // a query carries window start and window end
   typedef struct packed {
      op_type             op;
      logic [WIN_W-1:0]   arg_a;
      logic [WIN_W-1:0]   arg_b;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_CLOSE
   } bk_state_type;

endpackage

@@ rtl/windowed_sample_ring_buffer.sv @@
// Top level of the windowed sample ring buffer.
`timescale 1ns / 1ps
// Saves: one item a cycle while the back end is idle, written to the store from the item queue.
// Queries: the walk visits each stored entry (registered store read, then window compare into
//   the result register), then emits the closing item. Saves behind a query wait in the
//   4-deep item queue meanwhile.
// Reset (synchronous, active high) empties queue and store and sets capacity to 32.
// Stored contents are not cleared; a capacity write also empties the store.
module windowed_sample_ring_buffer
   import wsrb_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CAP_W-1:0]        csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [TS_W-1:0]         req_sample_timestamp,
   input  logic [PL_W-1:0]         req_sample_payload,
   input  logic signed [WIN_W-1:0] req_window_start,
   input  logic signed [WIN_W-1:0] req_window_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_sample,
   output logic [TS_W-1:0]         rsp_out_timestamp,
   output logic [PL_W-1:0]         rsp_out_payload,
   output logic [TS_W-1:0]         rsp_latest_timestamp,
   output logic                    rsp_last
);

   // classified items travel from front to back through the front's queue
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // front: takes each item unless its queue is full, packs the fields its operation uses, queues it
   wsrb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_sample_timestamp (req_sample_timestamp),
      .req_sample_payload   (req_sample_payload),
      .req_window_start     (req_window_start),
      .req_window_end       (req_window_end),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_pop              (cmd_pop)
   );

   // back: owns the store, head and fill; writes saves, walks queries
   // oldest to newest and holds each result item in its output register
   wsrb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_pop              (cmd_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_sample        (rsp_is_sample),
      .rsp_out_timestamp    (rsp_out_timestamp),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_latest_timestamp (rsp_latest_timestamp),
      .rsp_last             (rsp_last)
   );

endmodule

@@ rtl/wsrb_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module wsrb_front
   import wsrb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [TS_W-1:0]         req_sample_timestamp,
   input  logic [PL_W-1:0]         req_sample_payload,
   input  logic signed [WIN_W-1:0] req_window_start,
   input  logic signed [WIN_W-1:0] req_window_end,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  logic                    cmd_pop
);

   localparam int QD  = 4;
   localparam int QAW = $clog2(QD);

   cmd_type          q_ff [QD];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     cnt_ff, cnt_in;
   cmd_type          cls;
   logic             push, pop;

   // classify: pack the fields the operation needs into one command
   always_comb begin
      if (op_type'(req_operation) == OP_QUERY) begin
         cls.op    = OP_QUERY;
         cls.arg_a = req_window_start;
         cls.arg_b = req_window_end;
      end else begin
         cls.op    = OP_SAVE;
         cls.arg_a = {1'b0, req_sample_timestamp};
         cls.arg_b = req_sample_payload;
      end
   end

   assign req_stall = (cnt_ff == (QAW+1)'(QD));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ rtl/wsrb_back.sv @@
// Back end: sample store, save writer, query walker and result register.
`timescale 1ns / 1ps
module wsrb_back
   import wsrb_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CAP_W-1:0]  csr_write_data,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_sample,
   output logic [TS_W-1:0]   rsp_out_timestamp,
   output logic [PL_W-1:0]   rsp_out_payload,
   output logic [TS_W-1:0]   rsp_latest_timestamp,
   output logic              rsp_last
);

`include "windowed_sample_ring_buffer_defines.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

   // store
   logic [TS_W-1:0] mem_ts [DEPTH];
   logic [PL_W-1:0] mem_pl [DEPTH];
   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr;
   logic [TS_W-1:0] rd_ts_ff;
   logic [PL_W-1:0] rd_pl_ff;

   // control state
   bk_state_type             state_ff, state_in;
   logic [CAP_W-1:0]         cap_ff, cap_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [AW-1:0]            slot_ff, slot_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic signed [WIN_W-1:0]  wstart_ff, wstart_in;
   logic signed [WIN_W-1:0]  wend_ff, wend_in;
   logic [TS_W-1:0]          latest_ff, latest_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_is_sample_ff, rsp_is_sample_in;
   logic [TS_W-1:0] rsp_ts_ff, rsp_ts_in;
   logic [PL_W-1:0] rsp_pl_ff, rsp_pl_in;
   logic [TS_W-1:0] rsp_latest_ff, rsp_latest_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [CW-1:0]   cap_eff;
   logic [CAP_W-1:0] cap_clamp;
   logic [CW:0]     save_sum;
   logic [AW-1:0]   save_slot;
   logic [AW:0]     head_inc, slot_inc;
   logic [AW-1:0]   head_wrap, slot_wrap;
   logic            match, out_free;
   logic            walking, idle_save;

   // capacity clamped to 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_clamp = CAP_W'(1);
      end else if (cap_ff > DEPTH_C) begin
         cap_clamp = DEPTH_C;
      end else begin
         cap_clamp = cap_ff;
      end
   end
   assign cap_eff = CW'(cap_clamp);

   // slot after the newest entry, and the wrapped increments
   assign save_sum  = (CW+1)'(head_ff) + (CW+1)'(fill_ff);
   assign save_slot = (save_sum >= (CW+1)'(cap_eff)) ?
                      AW'(save_sum - (CW+1)'(cap_eff)) : AW'(save_sum);
   assign head_inc  = (AW+1)'(head_ff) + 1'b1;
   assign head_wrap = (head_inc == (AW+1)'(cap_eff)) ? '0 : AW'(head_inc);
   assign slot_inc  = (AW+1)'(slot_ff) + 1'b1;
   assign slot_wrap = (slot_inc == (AW+1)'(cap_eff)) ? '0 : AW'(slot_inc);

   assign match = ($signed({1'b0, rd_ts_ff}) > wstart_ff) &&
                  ($signed({1'b0, rd_ts_ff}) <= wend_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cap_in    = cap_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      wstart_in = wstart_ff;
      wend_in   = wend_ff;
      latest_in = latest_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = save_slot;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_is_sample_in = rsp_is_sample_ff;
      rsp_ts_in        = rsp_ts_ff;
      rsp_pl_in        = rsp_pl_ff;
      rsp_latest_in    = rsp_latest_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_SAVE) begin
                  mem_we = 1'b1;
                  if (fill_ff < cap_eff) begin
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     mem_waddr = head_ff;
                     head_in   = head_wrap;
                  end
               end else begin
                  wstart_in = cmd.arg_a;
                  wend_in   = cmd.arg_b;
                  latest_in = '0;
                  idx_in    = '0;
                  slot_in   = head_ff;
                  state_in  = (fill_ff == '0) ? BK_CLOSE : BK_READ;
               end
            end
         end
         BK_READ: begin
            mem_re   = 1'b1;
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (!match || out_free) begin
               if (match) begin
                  rsp_valid_in     = 1'b1;
                  rsp_is_sample_in = 1'b1;
                  rsp_ts_in        = rd_ts_ff;
                  rsp_pl_in        = rd_pl_ff;
                  rsp_latest_in    = '0;
                  rsp_last_in      = 1'b0;
                  if (rd_ts_ff > latest_ff) begin
                     latest_in = rd_ts_ff;
                  end
               end
               idx_in   = idx_ff + 1'b1;
               slot_in  = slot_wrap;
               state_in = (idx_ff + 1'b1 == fill_ff) ? BK_CLOSE : BK_READ;
            end
         end
         BK_CLOSE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_is_sample_in = 1'b0;
               rsp_ts_in        = '0;
               rsp_pl_in        = '0;
               rsp_latest_in    = latest_ff;
               rsp_last_in      = 1'b1;
               state_in         = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // a capacity write empties the store
      if (csr_write_enable) begin
         cap_in  = csr_write_data;
         fill_in = '0;
         head_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         head_ff      <= '0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wstart_ff        <= wstart_in;
      wend_ff          <= wend_in;
      rsp_is_sample_ff <= rsp_is_sample_in;
      rsp_ts_ff        <= rsp_ts_in;
      rsp_pl_ff        <= rsp_pl_in;
      rsp_latest_ff    <= rsp_latest_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ts[mem_waddr] <= cmd.arg_a[TS_W-1:0];
         mem_pl[mem_waddr] <= cmd.arg_b;
      end
      if (mem_re) begin
         rd_ts_ff <= mem_ts[slot_ff];
         rd_pl_ff <= mem_pl[slot_ff];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_sample        = rsp_is_sample_ff;
   assign rsp_out_timestamp    = rsp_ts_ff;
   assign rsp_out_payload      = rsp_pl_ff;
   assign rsp_latest_timestamp = rsp_latest_ff;
   assign rsp_last             = rsp_last_ff;

   assign walking   = (state_ff == BK_READ) || (state_ff == BK_CHECK);
   assign idle_save = (state_ff == BK_IDLE) && cmd_valid && (cmd.op == OP_SAVE);

   `WSRB_ASSERT(a_fill_within_cap, clock, reset, fill_ff <= cap_eff)
   `WSRB_ASSERT(a_head_within_cap, clock, reset, head_ff < AW'(cap_eff) || cap_eff == CW'(DEPTH))
   `WSRB_ASSERT(a_walk_within_fill, clock, reset, walking |-> idx_ff < fill_ff)
   `WSRB_ASSERT(a_save_stays_idle, clock, reset, idle_save |=> state_ff == BK_IDLE)
   `WSRB_ASSERT_ALWAYS(a_close_not_sample, clock, (rsp_valid_ff && rsp_last_ff) |-> !rsp_is_sample_ff)

endmodule
